[src/fli_fsd_pkg.sv]
// ----------------------------------------------------------------------------
// fli_fsd_pkg
// Shared types and constants of the animation frame stream decoder.
// ----------------------------------------------------------------------------
package fli_fsd_pkg;

  localparam int AddrBits = 16;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_TOTAL  = 2'd2
  } cfg_idx_t;

  // output command codes
  typedef enum logic [2:0] {
    CMD_PIXEL   = 3'd0,
    CMD_RUN     = 3'd1,
    CMD_PALETTE = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_DONE    = 3'd4
  } cmd_t;

  // chunk types
  localparam logic [15:0] ChunkColor = 16'd11;
  localparam logic [15:0] ChunkDelta = 16'd12;
  localparam logic [15:0] ChunkClear = 16'd13;
  localparam logic [15:0] ChunkBrun  = 16'd15;
  localparam logic [15:0] ChunkCopy  = 16'd16;

  // parse phases
  typedef enum logic [4:0] {
    PH_FSIZE, PH_FMAGIC, PH_FCHUNKS, PH_FRESV, PH_CSIZE, PH_CTYPE,
    PH_COL_CNT, PH_COL_SKIP, PH_COL_N, PH_COL_RGB,
    PH_LC_Y, PH_LC_LINES, PH_LC_PKTS, PH_LC_SKIP, PH_LC_SIZE, PH_LC_LIT, PH_LC_REP,
    PH_BR_PKTS, PH_BR_SIZE, PH_BR_REP, PH_BR_LIT,
    PH_COPY, PH_SKIP, PH_PAD, PH_DONE_PEND
  } phase_t;

  // one result word
  typedef struct packed {
    cmd_t                  command;
    logic [AddrBits-1:0]   pixel_address;
    logic [7:0]            run_length;
    logic [7:0]            pixel_value;
    logic [7:0]            palette_index;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  all_frames_done;
  } result_t;

endpackage

[src/fli_fsd_byte_if.sv]
// ----------------------------------------------------------------------------
// fli_fsd_byte_if
// Stream byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fli_fsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

[src/fli_fsd_cmd_if.sv]
// ----------------------------------------------------------------------------
// fli_fsd_cmd_if
// Decoded command channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fli_fsd_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] pixel_address;
  logic [7:0]  run_length;
  logic [7:0]  pixel_value;
  logic [7:0]  palette_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        all_frames_done;

  modport source (output valid, output command, output pixel_address, output run_length,
                  output pixel_value, output palette_index, output red, output green,
                  output blue, output all_frames_done, input ready);
  modport sink   (input valid, input command, input pixel_address, input run_length,
                  input pixel_value, input palette_index, input red, input green,
                  input blue, input all_frames_done, output ready);
endinterface

[src/fli_frame_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// fli_frame_stream_decoder_top
// Byte-serial parser of animation frames into pixel and palette commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries the stream one byte per word, starting at the first frame
//   header. out_if carries at most one command word per input byte: pixel
//   write, pixel run, palette write, clear frame or frame done.
//   cfg_we/cfg_index/cfg_wdata set frame width, frame height and the frame
//   total; write them only while the decoder is idle.
// Timing:
//   one byte is taken every cycle while the output register is not stalled;
//   the parse state updates in the same cycle and the command, if any,
//   appears in the output register in the cycle after the byte is accepted.
//   Bytes that produce no command leave no word. The byte rate is set by the
//   combinational parse step between input handshake and output register.
// Reset:
//   rst_n low clears the parser to the frame header phase, restores the
//   default registers (320 x 200, total 0) and empties the output register.
// Stall:
//   while out_if.ready is low and a word is held, in_if.ready is low too;
//   an empty output register keeps the input open.
// ----------------------------------------------------------------------------
module fli_frame_stream_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  fli_fsd_byte_if.sink         in_if,
  fli_fsd_cmd_if.source        out_if,
  input  logic                 cfg_we,
  input  fli_fsd_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import fli_fsd_pkg::*;

  typedef logic [AddrBits-1:0] addr_t;

  // configuration
  logic [10:0] width_r, height_r;
  logic [15:0] total_r;

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  fbi_r, fbi_nxt;
  logic [31:0] fa_r, fa_nxt;
  logic [15:0] frames_r, frames_nxt;
  logic [15:0] chunks_r, chunks_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic        parity_r, parity_nxt;
  logic [15:0] lines_r, lines_nxt;
  logic [15:0] pkts_r, pkts_nxt;
  addr_t       lstart_r, lstart_nxt;
  addr_t       waddr_r, waddr_nxt;
  logic [8:0]  run_r, run_nxt;
  logic [21:0] copy_r, copy_nxt;
  logic [7:0]  pal_r, pal_nxt;
  logic [15:0] colour_r, colour_nxt;

  // output register
  logic        out_valid_r;
  result_t     out_r;

  // step results
  logic        res_valid;
  result_t     res;
  logic        fire;
  logic        stopped;
  logic [31:0] gath;
  logic [2:0]  fbi_inc;
  logic        g2, g4;
  logic        pkt_end, line_end, chunk_end, nxt_chunk, frame_cpl, is_lc;
  logic [26:0] lc_prod;
  logic [21:0] copy_prod;
  logic [7:0]  neg_b;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign fire        = in_if.valid && in_if.ready;

  // field gathering and multipliers
  assign gath      = fa_r | ({24'd0, in_if.stream_byte} << {fbi_r[1:0], 3'b000});
  assign fbi_inc   = fbi_r + 3'd1;
  assign g2        = fbi_inc >= 3'd2;
  assign g4        = fbi_inc >= 3'd4;
  assign lc_prod   = gath[15:0] * width_r;
  assign copy_prod = width_r * height_r;
  assign neg_b     = 8'd0 - in_if.stream_byte;
  assign stopped   = (phase_r == PH_DONE_PEND || (phase_r == PH_FSIZE && fbi_r == 3'd0))
                     && frames_r >= total_r;

  // parse step
  always_comb begin
    phase_nxt  = phase_r;   fbi_nxt    = fbi_r;    fa_nxt     = fa_r;
    frames_nxt = frames_r;  chunks_nxt = chunks_r; kind_nxt   = kind_r;
    skip_nxt   = skip_r;    parity_nxt = parity_r; lines_nxt  = lines_r;
    pkts_nxt   = pkts_r;    lstart_nxt = lstart_r; waddr_nxt  = waddr_r;
    run_nxt    = run_r;     copy_nxt   = copy_r;   pal_nxt    = pal_r;
    colour_nxt = colour_r;
    res_valid  = 1'b0;
    res        = '0;
    res.command = CMD_PIXEL;
    pkt_end = 1'b0; line_end = 1'b0; chunk_end = 1'b0;
    nxt_chunk = 1'b0; frame_cpl = 1'b0; is_lc = 1'b0;

    // delayed frame done
    if (phase_r == PH_DONE_PEND) begin
      res_valid = 1'b1;
      res.command = CMD_DONE;
      res.all_frames_done = frames_r >= total_r;
      phase_nxt = PH_FSIZE;
      fbi_nxt = 3'd0;
      fa_nxt = '0;
    end

    if (!stopped) begin
      parity_nxt = !parity_r;
      unique case (phase_nxt)
        PH_FSIZE, PH_CSIZE: begin
          if (g4) begin
            skip_nxt = gath; fa_nxt = '0; fbi_nxt = 3'd0;
            phase_nxt = (phase_nxt == PH_FSIZE) ? PH_FMAGIC : PH_CTYPE;
          end else begin
            fa_nxt = gath; fbi_nxt = fbi_inc;
          end
        end
        PH_FMAGIC: begin
          if (g2) begin
            fa_nxt = '0; fbi_nxt = 3'd0; phase_nxt = PH_FCHUNKS;
          end else begin
            fa_nxt = gath; fbi_nxt = fbi_inc;
          end
        end
        PH_FCHUNKS: begin
          if (g2) begin
            chunks_nxt = gath[15:0]; fa_nxt = '0; fbi_nxt = 3'd0; phase_nxt = PH_FRESV;
          end else begin
            fa_nxt = gath; fbi_nxt = fbi_inc;
          end
        end
        PH_FRESV: begin
          if (fbi_r >= 3'd7) begin
            fbi_nxt = 3'd0;
            if (skip_r == 32'd0) begin
              res_valid = 1'b1;
              res.command = CMD_DONE;
              res.all_frames_done = frames_r >= total_r;
              phase_nxt = PH_FSIZE;
            end else if (chunks_r == 16'd0) begin
              frame_cpl = 1'b1;
            end else begin
              phase_nxt = PH_CSIZE;
            end
          end else begin
            fbi_nxt = fbi_inc;
          end
        end
        PH_CTYPE: begin
          if (g2) begin
            kind_nxt = gath[15:0]; fa_nxt = '0; fbi_nxt = 3'd0;
            priority case (gath[15:0])
              ChunkColor: phase_nxt = PH_COL_CNT;
              ChunkDelta: phase_nxt = PH_LC_Y;
              ChunkClear: begin
                res_valid = 1'b1;
                res.command = CMD_CLEAR;
                chunk_end = 1'b1;
              end
              ChunkBrun: begin
                lines_nxt = {5'd0, height_r};
                lstart_nxt = '0;
                if (height_r == 11'd0) chunk_end = 1'b1;
                else phase_nxt = PH_BR_PKTS;
              end
              ChunkCopy: begin
                copy_nxt = copy_prod;
                waddr_nxt = '0;
                if (copy_prod == 22'd0) chunk_end = 1'b1;
                else phase_nxt = PH_COPY;
              end
              default: begin
                skip_nxt = (skip_r > 32'd6) ? skip_r - 32'd6 : 32'd0;
                if (skip_r <= 32'd6) chunk_end = 1'b1;
                else phase_nxt = PH_SKIP;
              end
            endcase
          end else begin
            fa_nxt = gath; fbi_nxt = fbi_inc;
          end
        end
        PH_COL_CNT: begin
          if (g2) begin
            pkts_nxt = gath[15:0]; pal_nxt = 8'd0; fa_nxt = '0; fbi_nxt = 3'd0;
            if (gath[15:0] == 16'd0) chunk_end = 1'b1;
            else phase_nxt = PH_COL_SKIP;
          end else begin
            fa_nxt = gath; fbi_nxt = fbi_inc;
          end
        end
        PH_COL_SKIP: begin
          pal_nxt = pal_r + in_if.stream_byte;
          phase_nxt = PH_COL_N;
        end
        PH_COL_N: begin
          run_nxt = (in_if.stream_byte == 8'd0) ? 9'd256 : {1'b0, in_if.stream_byte};
          fbi_nxt = 3'd0;
          phase_nxt = PH_COL_RGB;
        end
        PH_COL_RGB: begin
          if (fbi_r == 3'd0) begin
            colour_nxt = {8'd0, in_if.stream_byte}; fbi_nxt = 3'd1;
          end else if (fbi_r == 3'd1) begin
            colour_nxt = {in_if.stream_byte, colour_r[7:0]}; fbi_nxt = 3'd2;
          end else begin
            fbi_nxt = 3'd0;
            res_valid = 1'b1;
            res.command = CMD_PALETTE;
            res.palette_index = pal_r;
            res.red = {colour_r[5:0], 2'b00};
            res.green = {colour_r[13:8], 2'b00};
            res.blue = {in_if.stream_byte[5:0], 2'b00};
            pal_nxt = pal_r + 8'd1;
            run_nxt = run_r - 9'd1;
            if (run_r == 9'd1) begin
              pkts_nxt = pkts_r - 16'd1;
              if (pkts_r == 16'd1) chunk_end = 1'b1;
              else phase_nxt = PH_COL_SKIP;
            end
          end
        end
        PH_LC_Y: begin
          if (g2) begin
            lstart_nxt = lc_prod[AddrBits-1:0]; fa_nxt = '0; fbi_nxt = 3'd0;
            phase_nxt = PH_LC_LINES;
          end else begin
            fa_nxt = gath; fbi_nxt = fbi_inc;
          end
        end
        PH_LC_LINES: begin
          if (g2) begin
            lines_nxt = gath[15:0]; fa_nxt = '0; fbi_nxt = 3'd0;
            if (gath[15:0] == 16'd0) chunk_end = 1'b1;
            else phase_nxt = PH_LC_PKTS;
          end else begin
            fa_nxt = gath; fbi_nxt = fbi_inc;
          end
        end
        PH_LC_PKTS, PH_BR_PKTS: begin
          is_lc = phase_nxt == PH_LC_PKTS;
          waddr_nxt = lstart_r;
          pkts_nxt = {8'd0, in_if.stream_byte};
          if (in_if.stream_byte == 8'd0) line_end = 1'b1;
          else phase_nxt = is_lc ? PH_LC_SKIP : PH_BR_SIZE;
        end
        PH_LC_SKIP: begin
          waddr_nxt = waddr_r + addr_t'(in_if.stream_byte);
          phase_nxt = PH_LC_SIZE;
        end
        PH_LC_SIZE, PH_BR_SIZE: begin
          is_lc = phase_nxt == PH_LC_SIZE;
          if (in_if.stream_byte == 8'd0) begin
            pkt_end = 1'b1;
          end else if (!in_if.stream_byte[7]) begin
            run_nxt = {1'b0, in_if.stream_byte};
            phase_nxt = is_lc ? PH_LC_LIT : PH_BR_REP;
          end else begin
            run_nxt = (neg_b == 8'd0) ? 9'd256 : {1'b0, neg_b};
            phase_nxt = is_lc ? PH_LC_REP : PH_BR_LIT;
          end
        end
        PH_LC_LIT, PH_BR_LIT, PH_COPY: begin
          is_lc = phase_nxt == PH_LC_LIT;
          res_valid = 1'b1;
          res.command = CMD_PIXEL;
          res.pixel_address = waddr_r;
          res.pixel_value = in_if.stream_byte;
          waddr_nxt = waddr_r + addr_t'(1);
          if (phase_nxt == PH_COPY) begin
            copy_nxt = copy_r - 22'd1;
            if (copy_r == 22'd1) chunk_end = 1'b1;
          end else begin
            run_nxt = run_r - 9'd1;
            if (run_r == 9'd1) pkt_end = 1'b1;
          end
        end
        PH_LC_REP, PH_BR_REP: begin
          is_lc = phase_nxt == PH_LC_REP;
          res_valid = 1'b1;
          res.command = CMD_RUN;
          res.pixel_address = waddr_r;
          res.run_length = run_r[7:0];
          res.pixel_value = in_if.stream_byte;
          waddr_nxt = waddr_r + addr_t'(run_r);
          pkt_end = 1'b1;
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_r == 32'd1) chunk_end = 1'b1;
        end
        PH_PAD: nxt_chunk = 1'b1;
        default: begin
          phase_nxt = PH_FSIZE; fbi_nxt = 3'd0; fa_nxt = '0;
        end
      endcase

      // end-of-packet, line, chunk and frame bookkeeping
      if (pkt_end) begin
        pkts_nxt = pkts_r - 16'd1;
        if (pkts_r == 16'd1) line_end = 1'b1;
        else phase_nxt = is_lc ? PH_LC_SKIP : PH_BR_SIZE;
      end
      if (line_end) begin
        lstart_nxt = lstart_r + addr_t'(width_r);
        lines_nxt = lines_r - 16'd1;
        if (lines_r == 16'd1) chunk_end = 1'b1;
        else phase_nxt = is_lc ? PH_LC_PKTS : PH_BR_PKTS;
      end
      if (chunk_end) begin
        if (parity_nxt) phase_nxt = PH_PAD;
        else nxt_chunk = 1'b1;
      end
      if (nxt_chunk) begin
        chunks_nxt = chunks_r - 16'd1;
        if (chunks_r == 16'd1) frame_cpl = 1'b1;
        else phase_nxt = PH_CSIZE;
      end
      if (frame_cpl) begin
        frames_nxt = frames_r + 16'd1;
        fbi_nxt = 3'd0;
        fa_nxt = '0;
        if (res_valid) begin
          phase_nxt = PH_DONE_PEND;
        end else begin
          res_valid = 1'b1;
          res.command = CMD_DONE;
          res.all_frames_done = frames_nxt >= total_r;
          phase_nxt = PH_FSIZE;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd320;
      height_r <= 11'd200;
      total_r  <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata[10:0];
        CFG_HEIGHT: height_r <= cfg_wdata[10:0];
        CFG_TOTAL:  total_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FSIZE; fbi_r <= '0; fa_r <= '0; frames_r <= '0;
      chunks_r <= '0; kind_r <= '0; skip_r <= '0; parity_r <= 1'b0;
      lines_r <= '0; pkts_r <= '0; lstart_r <= '0; waddr_r <= '0;
      run_r <= '0; copy_r <= '0; pal_r <= '0; colour_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt; fbi_r <= fbi_nxt; fa_r <= fa_nxt; frames_r <= frames_nxt;
      chunks_r <= chunks_nxt; kind_r <= kind_nxt; skip_r <= skip_nxt;
      parity_r <= parity_nxt; lines_r <= lines_nxt; pkts_r <= pkts_nxt;
      lstart_r <= lstart_nxt; waddr_r <= waddr_nxt; run_r <= run_nxt;
      copy_r <= copy_nxt; pal_r <= pal_nxt; colour_r <= colour_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.command         = out_r.command;
  assign out_if.pixel_address   = out_r.pixel_address;
  assign out_if.run_length      = out_r.run_length;
  assign out_if.pixel_value     = out_r.pixel_value;
  assign out_if.palette_index   = out_r.palette_index;
  assign out_if.red             = out_r.red;
  assign out_if.green           = out_r.green;
  assign out_if.blue            = out_r.blue;
  assign out_if.all_frames_done = out_r.all_frames_done;

`ifndef NO_ASSERTIONS
  // a pending frame done always leaves as the next word
  a_done_pend: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == PH_DONE_PEND |=> out_valid_r && out_r.command == CMD_DONE)
    else $error("pending frame done not emitted");

  // bytes past the frame total leave parity and count untouched
  a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == PH_FSIZE && fbi_r == 3'd0 && frames_r >= total_r
    |=> $stable(parity_r) && $stable(frames_r))
    else $error("stopped decoder changed state");

  // four-byte fields never run past their last byte
  a_gather4: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FSIZE || phase_r == PH_CSIZE |-> fbi_r < 3'd4)
    else $error("field byte index out of range");

  // the done flag only rides on frame done words
  a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.command != CMD_DONE |-> !out_r.all_frames_done)
    else $error("all frames done on a non-done word");
`endif

endmodule
